@@ rtl/fmp4bf_pkg.sv @@
// ----------------------------------------------------------------------------
// fmp4bf_pkg
// Box type codes, box classes and the type lookup for the fMP4 box framer.
// ----------------------------------------------------------------------------
package fmp4bf_pkg;

    localparam logic [31:0] FOURCC_FTYP = 32'h6674_7970;
    localparam logic [31:0] FOURCC_FREE = 32'h6672_6565;
    localparam logic [31:0] FOURCC_MOOV = 32'h6D6F_6F76;
    localparam logic [31:0] FOURCC_STYP = 32'h7374_7970;
    localparam logic [31:0] FOURCC_MOOF = 32'h6D6F_6F66;
    localparam logic [31:0] FOURCC_MDAT = 32'h6D64_6174;

    localparam int unsigned HDR_BYTES = 8;

    typedef enum logic [1:0] {
        CLASS_INIT   = 2'd0,
        CLASS_HEADER = 2'd1,
        CLASS_DATA   = 2'd2,
        CLASS_DROP   = 2'd3
    } t_box_class;

    function automatic t_box_class class_of_type(input logic [31:0] type_word);
        t_box_class cls;
        case (type_word)
            FOURCC_FTYP, FOURCC_FREE, FOURCC_MOOV: cls = CLASS_INIT;
            FOURCC_STYP, FOURCC_MOOF:              cls = CLASS_HEADER;
            FOURCC_MDAT:                           cls = CLASS_DATA;
            default:                               cls = CLASS_DROP;
        endcase
        return cls;
    endfunction

endpackage

@@ rtl/fmp4_box_segment_framer_unit.sv @@
// ----------------------------------------------------------------------------
// fmp4_box_segment_framer_unit
// Frames a fragmented ISO BMFF byte stream into per-box records.
// ----------------------------------------------------------------------------
// Input stream: one byte per transaction on s_axis. Each box starts with a
// big-endian size and a four-character type; the byte at which a box ends
// produces one record on m_axis, every other byte produces nothing.
// Record: tdata carries type, size and the count of segments completed before
// the box; tuser carries the class (init, header, data, dropped) and the
// malformed flag (size below 8, framed as an 8-byte box); tlast marks an
// accepted mdat, which ends a segment and returns the order to init.
// Pipeline: each byte is framed while it sits in the input register, and
// the record of a box end is offered from the output register.
// Throughput: one byte per cycle unless a box end stalls; framing is one counter add and compare.
// Reset (synchronous, active low) empties both registers, clears the byte
// position, the header and the segment count, and sets the order to init.
// A stalled receiver holds the record in the output register; bytes that
// do not end a box keep flowing, and s_axis_tready drops only when a box
// end meets a full, stalled output register.
// ----------------------------------------------------------------------------
module fmp4_box_segment_framer_unit
    import fmp4bf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [31:0] box_type_code, [63:32] box_length,
                                         // [95:64] segment_number
    output logic         m_axis_tlast,   // segment_end
    output logic [2:0]   m_axis_tuser    // [1:0] category, [2] malformed
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [63:0] r_hdr;
    logic [31:0] r_pos;
    t_box_class  r_order;
    logic [31:0] r_seg_cnt;

    logic        r_out_valid;
    logic [95:0] r_out_data;
    logic        r_out_last;
    logic [2:0]  r_out_user;

    logic [63:0] n_hdr;
    logic [31:0] n_pos;
    t_box_class  n_order;
    logic [31:0] n_seg_cnt;

    logic [31:0] w_size;
    logic [31:0] w_type;
    logic        w_bad;
    logic [31:0] w_eff;
    logic [32:0] w_pos_inc;
    logic        w_last;
    t_box_class  w_cls;
    t_box_class  w_cat;
    logic        w_seg_end;
    logic        w_out_free;
    logic        w_stall;
    logic        w_fire;

    always_comb begin
        n_hdr = (r_pos < 32'(HDR_BYTES)) ? {r_hdr[55:0], r_in_byte} : r_hdr;
        w_size = n_hdr[63:32];
        w_type = n_hdr[31:0];
        w_bad = w_size < 32'(HDR_BYTES);
        w_eff = w_bad ? 32'(HDR_BYTES) : w_size;
        w_pos_inc = {1'b0, r_pos} + 33'd1;
        w_last = (r_pos >= 32'(HDR_BYTES - 1)) && !(w_pos_inc < {1'b0, w_eff});
        w_cls = class_of_type(w_type);
        w_cat = w_cls;
        w_seg_end = 1'b0;
        n_order = r_order;
        n_seg_cnt = r_seg_cnt;
        if (w_cls == CLASS_DROP || w_cls < r_order) begin
            w_cat = CLASS_DROP;
        end else if (w_cls == CLASS_DATA) begin
            w_seg_end = 1'b1;
            n_seg_cnt = r_seg_cnt + 32'd1;
            n_order = CLASS_INIT;
        end else begin
            n_order = w_cls;
        end
        n_pos = w_last ? 32'd0 : w_pos_inc[31:0];
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_stall       = r_in_valid && w_last && !w_out_free;
    assign w_fire        = r_in_valid && !w_stall;
    assign s_axis_tready = !w_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr     <= '0;
            r_pos     <= '0;
            r_order   <= CLASS_INIT;
            r_seg_cnt <= '0;
        end else if (w_fire) begin
            r_hdr <= w_last ? 64'd0 : n_hdr;
            r_pos <= n_pos;
            if (w_last) begin
                r_order   <= n_order;
                r_seg_cnt <= n_seg_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && w_last) begin
            r_out_data <= {r_seg_cnt, w_size, w_type};
            r_out_last <= w_seg_end;
            r_out_user <= {w_bad, w_cat};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

`ifndef ASSERT_OFF
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == CLASS_DATA)
        else $error("segment end on a record that is not a data box");

    a_bad_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[2] == (m_axis_tdata[63:32] < 32'(HDR_BYTES)))
        else $error("malformed flag disagrees with box size");

    a_seg_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_last && w_seg_end |=> r_seg_cnt == $past(r_seg_cnt) + 32'd1)
        else $error("segment count did not advance at segment end");

    a_order_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_last && w_seg_end |=> r_order == CLASS_INIT && r_pos == 32'd0)
        else $error("order or position not returned to start after segment end");
`endif

endmodule
